// ===== design/mscd_pkg.sv =====
// Package for the sequence cut detector: shared widths, register indexes and request codes.
// Used by mscd_decide and the top level; depends on nothing.
package mscd_pkg;
	localparam int StoreDepthDefault = 16384;
	localparam int DistW = 16;
	localparam int IdxW  = 14;
	localparam int CntW  = 15;
	localparam int SumW  = 31;
	localparam int WinW  = 13;
	localparam int GainW = 12;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 13;

	localparam logic [CfgIdxW-1:0] RegWindow = 1'b0;
	localparam logic [CfgIdxW-1:0] RegGain   = 1'b1;

	localparam logic ReqLoad  = 1'b0;
	localparam logic ReqQuery = 1'b1;
endpackage

// ===== design/mscd_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on nothing.
module mscd_ram #(
	parameter int Width = 16,
	parameter int Depth = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write when enabled; the read is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== design/mscd_decide.sv =====
// Cut decision: two registered multiplies, then a compare.
// Depends on mscd_pkg.
module mscd_decide #(
	parameter int CountW = mscd_pkg::CntW
) (
	input  logic                        clk,
	input  logic                        start,
	input  logic [mscd_pkg::DistW-1:0]  diff,
	input  logic [CountW-1:0]           count_m1,
	input  logic [mscd_pkg::SumW-1:0]   sum,
	input  logic [mscd_pkg::GainW-1:0]  gain,
	output logic                        done,
	output logic                        cut
);
	import mscd_pkg::*;

	localparam int LhsW = DistW + CountW + 8;
	localparam int RhsW = SumW + GainW;
	localparam int CmpW = (LhsW > RhsW) ? LhsW : RhsW;

	logic [DistW+CountW-1:0] lhs_s1;
	logic [SumW+GainW-1:0]   rhs_s1;
	logic                    go_s1;

	// Products are registered, the compare follows in the next cycle.
	always_ff @(posedge clk) begin
		lhs_s1 <= diff * count_m1;
		rhs_s1 <= sum * gain;
		go_s1  <= start;
		done   <= go_s1;
		cut    <= CmpW'({lhs_s1, 8'd0}) > CmpW'(rhs_s1);
	end
endmodule

// ===== design/mst_sequence_cut_detector_unit.sv =====
// Top level of the MST sequence cut detector.
// A load raises its result at the accepting edge; a query outside the testable range goes
// through S_OUT; a testable query reads the window entries one at a time through the single
// distance RAM port, then the tested edge, then decides. A new request is taken only once the
// previous result has been taken. Reset clears count, step sum, previous distance and the
// result valid, sets window 1 and gain 256; the distance store is undefined until written.
module mst_sequence_cut_detector_unit #(
	parameter int STORE_DEPTH = mscd_pkg::StoreDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mscd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mscd_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic                          restart,
	input  logic [mscd_pkg::DistW-1:0]    edge_distance,
	input  logic [mscd_pkg::IdxW-1:0]     edge_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          evaluated,
	output logic                          is_cut,
	output logic [mscd_pkg::DistW-1:0]    left_peak,
	output logic [mscd_pkg::DistW-1:0]    right_peak,
	output logic [mscd_pkg::CntW-1:0]     stored_count,
	output logic                          overflow
);
	import mscd_pkg::*;

	localparam int AddrW = $clog2(STORE_DEPTH);
	localparam int CW    = AddrW + 1;
	localparam int TW    = ((CW > IdxW) ? CW : IdxW) + 2;

	typedef enum logic [2:0] {S_IDLE, S_LEFT, S_RIGHT, S_MID, S_DEC, S_WAIT, S_OUT} state_t;

	state_t              state_q;
	logic [WinW-1:0]     win_q;
	logic [GainW-1:0]    gain_q;
	logic [CW-1:0]       count_q;
	logic [SumW-1:0]     sum_q;
	logic [DistW-1:0]    prev_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       addr_q;
	logic [WinW:0]       left_q;
	logic                rd_q;
	logic                side_q;
	logic [DistW-1:0]    lp_q, rp_q;
	logic                ram_we;
	logic [AddrW-1:0]    ram_addr;
	logic [DistW-1:0]    ram_rdata;
	logic                accept;
	logic                dec_start, dec_done, dec_cut;
	logic [DistW-1:0]    lower;
	logic [DistW-1:0]    dmid_q;
	logic [TW-1:0]       need;
	logic                testable;
	logic [DistW:0]      step;
	logic [SumW:0]       sum_new;
	logic [CW-1:0]       cnt_base;
	logic [SumW-1:0]     sum_base;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign accept   = in_valid && !in_stall;

	// Testable-range check on the incoming query.
	assign need     = TW'({win_q, 1'b1});
	assign testable = (win_q != '0) && (TW'(count_q) >= need)
		&& (TW'(edge_index) >= TW'(win_q))
		&& (TW'(edge_index) + TW'(win_q) < TW'(count_q));

	// Load path: restart, step and saturating sum.
	assign cnt_base = restart ? '0 : count_q;
	assign sum_base = restart ? '0 : sum_q;
	assign step     = (edge_distance > prev_q) ? {1'b0, edge_distance - prev_q}
		: {1'b0, prev_q - edge_distance};
	assign sum_new  = {1'b0, sum_base} + {{(SumW-DistW){1'b0}}, step};

	assign ram_we   = accept && (req_type == ReqLoad) && (cnt_base < CW'(STORE_DEPTH));
	assign ram_addr = ram_we ? cnt_base[AddrW-1:0] : addr_q[AddrW-1:0];

	mscd_ram #(.Width(DistW), .Depth(STORE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(edge_distance), .rdata(ram_rdata)
	);

	assign lower     = (lp_q < rp_q) ? lp_q : rp_q;
	assign dec_start = (state_q == S_DEC);

	mscd_decide #(.CountW(CW)) u_dec (
		.clk(clk), .start(dec_start), .diff(dmid_q - lower),
		.count_m1(CW'(count_q - 1'b1)), .sum(sum_q), .gain(gain_q),
		.done(dec_done), .cut(dec_cut)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= WinW'(1);
			gain_q <= GainW'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				RegWindow: win_q  <= cfg_data;
				RegGain:   gain_q <= cfg_data[GainW-1:0];
				default:   ;
			endcase
		end
	end

	// Sequencer: loads finish at once, testable queries walk the two windows then decide, others go to S_OUT.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
			out_valid <= 1'b0;
			rd_q      <= 1'b0;
			side_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && req_type == ReqLoad) begin
						evaluated  <= 1'b0;
						is_cut     <= 1'b0;
						left_peak  <= '0;
						right_peak <= '0;
						if (cnt_base >= CW'(STORE_DEPTH)) begin
							overflow     <= 1'b1;
							stored_count <= CntW'(cnt_base);
						end else begin
							overflow     <= 1'b0;
							stored_count <= CntW'(cnt_base + 1'b1);
							count_q      <= cnt_base + 1'b1;
							prev_q       <= edge_distance;
							sum_q        <= (cnt_base == '0) ? sum_base
								: (sum_new[SumW] ? {SumW{1'b1}} : sum_new[SumW-1:0]);
						end
						out_valid <= 1'b1;
					end else if (accept) begin
						evaluated    <= 1'b0;
						is_cut       <= 1'b0;
						left_peak    <= '0;
						right_peak   <= '0;
						overflow     <= 1'b0;
						stored_count <= CntW'(count_q);
						if (testable) begin
							idx_q   <= CW'(edge_index);
							addr_q  <= CW'(edge_index) - CW'(win_q);
							left_q  <= {1'b0, win_q};
							lp_q    <= '0;
							rp_q    <= '0;
							side_q  <= 1'b0;
							state_q <= S_LEFT;
						end else begin
							state_q <= S_OUT;
						end
					end else if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
					end
				end
				S_LEFT, S_RIGHT: begin
					// Issue one read a cycle; fold the returned word into the peak.
					if (rd_q) begin
						if (!side_q && ram_rdata > lp_q) lp_q <= ram_rdata;
						if (side_q && ram_rdata > rp_q) rp_q <= ram_rdata;
					end
					if (left_q != '0) begin
						rd_q   <= 1'b1;
						side_q <= (state_q == S_RIGHT);
						left_q <= left_q - 1'b1;
						addr_q <= addr_q + 1'b1;
					end else if (state_q == S_LEFT) begin
						rd_q    <= 1'b0;
						state_q <= S_RIGHT;
						left_q  <= {1'b0, win_q};
						addr_q  <= idx_q + 1'b1;
					end else begin
						rd_q    <= 1'b0;
						addr_q  <= idx_q;
						state_q <= S_MID;
					end
				end
				S_MID: begin
					// The tested edge is read from the RAM first; the registered word is then taken into dmid_q.
					if (!rd_q) begin
						rd_q <= 1'b1;
					end else begin
						rd_q    <= 1'b0;
						dmid_q  <= ram_rdata;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (dec_done) begin
						evaluated  <= 1'b1;
						is_cut     <= (dmid_q > lower) && dec_cut;
						left_peak  <= lp_q;
						right_peak <= rp_q;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A stalled result must hold while the block waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stored_count))
		else $error("result changed under stall");
	// Input is never taken while the left window is walked.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEFT) |-> in_stall)
		else $error("request accepted during window walk");
	// The count never exceeds the store depth.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("count beyond store depth");
endmodule

// ===== verif/mst_sequence_cut_detector_unit_test.sv =====
// Self-checking MST sequence cut detector testbench: directed, config-extreme, random and back-pressure tests.
// Predicts every result in SystemVerilog and compares it with the block's output.
// Depends on mscd_pkg and mst_sequence_cut_detector_unit.
module mst_sequence_cut_detector_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mscd_pkg::*;

	// A small store, so that the full-store case is reached quickly.
	localparam int Depth = 64;
	localparam int WatchLimit = 60000;

	typedef struct packed {
		logic            evaluated;
		logic            is_cut;
		logic [DistW-1:0] left_peak;
		logic [DistW-1:0] right_peak;
		logic [CntW-1:0]  stored_count;
		logic            overflow;
	} cut_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                req_type = ReqLoad;
	logic                restart = 1'b0;
	logic [DistW-1:0]    edge_distance = '0;
	logic [IdxW-1:0]     edge_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                evaluated;
	logic                is_cut;
	logic [DistW-1:0]    left_peak;
	logic [DistW-1:0]    right_peak;
	logic [CntW-1:0]     stored_count;
	logic                overflow;

	// Predictor state, kept apart from the block.
	logic [DistW-1:0] dist_mem [Depth];
	int unsigned      edge_count;
	longint unsigned  step_total;
	logic [DistW-1:0] last_dist;
	int unsigned      win_cfg;
	int unsigned      gain_cfg;

	cut_result_t pending_results[$];
	int          errors = 0;
	int          hold_cycles = 0;
	int          idle_run = 0;

	mst_sequence_cut_detector_unit #(.STORE_DEPTH(Depth)) i_dut (.*);

	always #5 clk = ~clk;

	// Reference behaviour of one request; updates the predictor state.
	function automatic cut_result_t predict_cut(logic rq, logic rs, logic [DistW-1:0] d,
			logic [IdxW-1:0] ix);
		cut_result_t r;
		logic [DistW-1:0] lower;
		longint unsigned stp;
		r = '0;
		if (rq == ReqLoad) begin
			if (rs) begin
				edge_count = 0;
				step_total = 0;
			end
			if (edge_count >= Depth) begin
				r.overflow = 1'b1;
			end else begin
				if (edge_count > 0) begin
					stp = (d > last_dist) ? d - last_dist : last_dist - d;
					step_total += stp;
					if (step_total > 64'h7FFF_FFFF) step_total = 64'h7FFF_FFFF;
				end
				dist_mem[edge_count] = d;
				last_dist = d;
				edge_count++;
			end
		end else if (win_cfg >= 1 && edge_count >= 2 * win_cfg + 1 && ix >= win_cfg
				&& ix < edge_count - win_cfg) begin
			r.evaluated = 1'b1;
			for (int k = ix - win_cfg; k < ix; k++)
				if (dist_mem[k] > r.left_peak) r.left_peak = dist_mem[k];
			for (int k = ix + 1; k <= ix + win_cfg; k++)
				if (dist_mem[k] > r.right_peak) r.right_peak = dist_mem[k];
			lower = (r.left_peak < r.right_peak) ? r.left_peak : r.right_peak;
			if (dist_mem[ix] > lower)
				r.is_cut = (longint'(dist_mem[ix] - lower) * (edge_count - 1) * 256)
					> (step_total * gain_cfg);
		end
		r.stored_count = edge_count[CntW-1:0];
		return r;
	endfunction

	function automatic int gap_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one request and waits until it is taken; leaves valid high when no gap follows.
	task automatic send_request(logic rq, logic rs, logic [DistW-1:0] d, logic [IdxW-1:0] ix);
		int gap;
		cut_result_t predicted;
		in_valid <= 1'b1;
		req_type <= rq;
		restart <= rs;
		edge_distance <= d;
		edge_index <= ix;
		do @(posedge clk); while (in_stall);
		predicted = predict_cut(rq, rs, d, ix);
		pending_results.insert(pending_results.size(), predicted);
		gap = (idle_run > 0) ? 0 : gap_length();
		if (idle_run > 0) idle_run--;
		else if ($urandom_range(0, 199) == 0) idle_run = $urandom_range(20, 80);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * win_cfg + 10) @(posedge clk);
	endtask

	// Registers change only with the block idle.
	task automatic write_reg(logic [CfgIdxW-1:0] ix, int unsigned value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= value[CfgDataW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ix == RegWindow) win_cfg = value;
		else gain_cfg = value;
		@(posedge clk);
	endtask

	function automatic logic [DistW-1:0] pick_distance();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return DistW'(last_dist + $urandom_range(0, 64) - 32);
			3: return DistW'($urandom_range(0, 2000));
			default: return DistW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_request(ReqQuery, 1'b0, 16'h0, 14'd0);
		send_request(ReqLoad, 1'b0, 16'h0000, 14'h3FFF);
		send_request(ReqLoad, 1'b0, 16'hFFFF, 14'd0);
		send_request(ReqQuery, 1'b0, 16'hFFFF, 14'd1);
		send_request(ReqLoad, 1'b0, 16'h0000, 14'd0);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd1);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd0);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd2);
		send_request(ReqQuery, 1'b0, 16'h0, 14'h3FFF);
		// Restart: the first load after it adds no step.
		send_request(ReqLoad, 1'b1, 16'h0100, 14'd0);
		send_request(ReqLoad, 1'b0, 16'h0100, 14'd0);
		send_request(ReqLoad, 1'b0, 16'h8000, 14'd0);
		send_request(ReqLoad, 1'b0, 16'h0100, 14'd0);
		send_request(ReqLoad, 1'b0, 16'h0120, 14'd0);
		send_request(ReqQuery, 1'b1, 16'h0, 14'd2);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd3);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd1);
	endtask

	// Extreme register settings: widest window, largest and zero gain.
	task automatic test_config_extremes();
		write_reg(RegWindow, 8191);
		write_reg(RegGain, 4095);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd2);
		send_request(ReqQuery, 1'b0, 16'h0, 14'h1FFF);
		write_reg(RegWindow, 1);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd2);
		write_reg(RegGain, 0);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd2);
		send_request(ReqQuery, 1'b0, 16'h0, 14'd3);
	endtask

	// Phases of random settings, each a restarted run of loads with queries mixed in.
	task automatic test_random_sequences(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(0, 4))
				0: write_reg(RegWindow, 1);
				1: write_reg(RegWindow, $urandom_range(2, 4));
				default: write_reg(RegWindow, $urandom_range(1, 31));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(RegGain, 0);
				1: write_reg(RegGain, 4095);
				default: write_reg(RegGain, $urandom_range(0, 1024));
			endcase
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 75) : $urandom_range(5, 50);
			send_request(ReqLoad, 1'b1, pick_distance(), IdxW'($urandom));
			sent++;
			for (int n = 0; n < len; n++) begin
				if ($urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 5) == 0)
						send_request(ReqQuery, 1'($urandom), DistW'($urandom),
							IdxW'($urandom));
					else
						send_request(ReqQuery, 1'($urandom), DistW'($urandom),
							IdxW'($urandom_range(0, edge_count + 1)));
				end else begin
					send_request(ReqLoad, $urandom_range(0, 40) == 0, pick_distance(),
						IdxW'($urandom));
				end
				sent++;
			end
		end
	endtask

	// Receiver holds off while the sender keeps offering, then the sender waits for all results and offers more queries.
	task automatic test_backpressure();
		write_reg(RegWindow, 2);
		hold_cycles = 300;
		for (int n = 0; n < 12; n++) send_request(ReqLoad, 1'b0, pick_distance(), 14'd0);
		for (int n = 0; n < 8; n++)
			send_request(ReqQuery, 1'b0, 16'h0, IdxW'($urandom_range(0, 14)));
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		for (int n = 0; n < 6; n++)
			send_request(ReqQuery, 1'b0, 16'h0, IdxW'($urandom_range(0, 14)));
	endtask

	// Receiver stall: random gaps, a counted long hold when asked.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_left = gap_length();
			end
		end
	end

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Result checker: each result against the oldest prediction.
	always @(posedge clk) begin
		cut_result_t exp_r;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("evaluated", longint'(exp_r.evaluated), longint'(evaluated));
				check_field("is_cut", longint'(exp_r.is_cut), longint'(is_cut));
				check_field("left_peak", longint'(exp_r.left_peak), longint'(left_peak));
				check_field("right_peak", longint'(exp_r.right_peak), longint'(right_peak));
				check_field("stored_count", longint'(exp_r.stored_count),
					longint'(stored_count));
				check_field("overflow", longint'(exp_r.overflow), longint'(overflow));
			end
		end
	end

	// Watchdog over cycles in which no request or result moves.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
			if (quiet >= WatchLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		edge_count = 0;
		step_total = 0;
		last_dist = '0;
		win_cfg = 1;
		gain_cfg = 256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random_sequences(1850);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
design/mscd_pkg.sv
design/mscd_ram.sv
design/mscd_decide.sv
design/mst_sequence_cut_detector_unit.sv
verif/mst_sequence_cut_detector_unit_test.sv
